FILE: rtl/savs_pkg.sv
package savs_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [31:0] cycle_stamp;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  way;
        logic        writeback_needed;
        logic [31:0] victim_block_address;
    } t_rsp;

    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_TOUCH = 2'd1;
    localparam logic [1:0] MODE_DIRTY = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    localparam logic [1:0] ST_FILLED  = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_FILLHIT = 2'd2;
    localparam logic [1:0] ST_MISS    = 2'd3;

    localparam logic [1:0] REG_REPL = 2'd0;
    localparam logic [1:0] REG_WB   = 2'd1;

    // one way seen by the scan unit
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] stamp;
    } t_way_view;

endpackage

FILE: rtl/savs_scan.sv
// shared compare unit: takes one way per cycle while i_step is high, keeping hit, first invalid, min stamp
module savs_scan #(
    parameter int WAY_W = 3
) (
    input  logic                   i_clk,
    input  logic                   i_clear,
    input  logic                   i_step,
    input  logic [WAY_W-1:0]       i_way,
    input  logic                   i_skip_en,
    input  logic [WAY_W-1:0]       i_skip,
    input  savs_pkg::t_way_view    i_view,
    output logic                   o_hit,
    output logic [WAY_W-1:0]       o_hit_way,
    output logic                   o_inv,
    output logic [WAY_W-1:0]       o_inv_way,
    output logic [WAY_W-1:0]       o_min_way
);
    import savs_pkg::*;

    logic              r_hit, r_inv, r_have;
    logic [WAY_W-1:0]  r_hit_way, r_inv_way, r_min_way;
    logic [31:0]       r_min;
    logic              skip;

    assign skip = i_skip_en && (i_skip == i_way);

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_hit  <= 1'b0;
            r_inv  <= 1'b0;
            r_have <= 1'b0;
        end else if (i_step) begin
            if (i_view.hit && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= i_way;
            end
            if (!i_view.valid && !r_inv) begin
                r_inv     <= 1'b1;
                r_inv_way <= i_way;
            end
            if (!skip && (!r_have || i_view.stamp < r_min)) begin
                r_have    <= 1'b1;
                r_min     <= i_view.stamp;
                r_min_way <= i_way;
            end
        end
    end

    assign o_hit     = r_hit;
    assign o_hit_way = r_hit_way;
    assign o_inv     = r_inv;
    assign o_inv_way = r_inv_way;
    assign o_min_way = r_min_way;
endmodule

FILE: rtl/set_assoc_victim_select_unit.sv
// channel | dir | handshake              | payload
// req     | in  | i_req_valid/o_req_ready | i_req (t_req)
// rsp     | out | o_rsp_valid/i_rsp_ready | o_rsp (t_rsp)
// cfg     | in  | apb psel/penable/pwrite | paddr, pwdata, prdata
// a mark, a fill hit or a fill into an invalid way needs one scan of the set; a fill into a
// full set also reads the oldest way, and when that way is not done scans again without it
// the scan reads one way per cycle from the line memories
// after reset a clearing pass over all SETS*WAYS lines zeroes valid/dirty/done; no item is taken
// the result waits in its register; the next item is taken the cycle after it has left
module set_assoc_victim_select_unit #(
    parameter int WAYS        = 8,
    parameter int SETS        = 64,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  savs_pkg::t_req     i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output savs_pkg::t_rsp     o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import savs_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int SBITS = $clog2(SETS);
    localparam int TAG_W = ADDR_WIDTH - OFF_W - SBITS;
    localparam int LINES = SETS * WAYS;
    localparam int IDX_W = $clog2(LINES);
    localparam int FLAG_W = 3;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_VIC   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // memories; flags per way packed as {valid, dirty, done}
    logic [TAG_W-1:0]  m_tag   [LINES];
    logic [31:0]       m_stamp [LINES];
    logic [FLAG_W-1:0] m_flag  [LINES];

    logic [2:0]        r_state;
    logic [WAY_W:0]    r_cnt;
    logic [IDX_W-1:0]  r_clr_idx;
    t_req              r_req;
    t_rsp              r_rsp;
    logic              r_repl, r_wbm;
    logic              r_rd_ok;
    logic [WAY_W-1:0]  r_rd_way;
    logic [TAG_W-1:0]  r_rd_tag;
    logic [31:0]       r_rd_stamp;
    logic [FLAG_W-1:0] r_rd_flag;
    logic [WAY_W-1:0]  r_skip;
    logic              r_pass2;

    logic [ADDR_WIDTH-1:0] addr;
    logic [SET_W-1:0]      set;
    logic [TAG_W-1:0]      tag;
    logic [WAY_W-1:0]      rd_way;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic                  sc_clear, sc_hit, sc_inv;
    logic [WAY_W-1:0]      sc_hit_way, sc_inv_way, sc_min_way;
    t_way_view             view;
    logic                  cfg_wr;

    assign addr = r_req.address[ADDR_WIDTH-1:0];
    generate
        if (SBITS > 0) begin : g_set
            assign set = addr[OFF_W +: SBITS];
        end else begin : g_noset
            assign set = '0;
        end
    endgenerate
    assign tag = addr[ADDR_WIDTH-1 -: TAG_W];

    function automatic logic [IDX_W-1:0] idx(input logic [SET_W-1:0] s,
                                             input logic [WAY_W-1:0] w);
        logic [IDX_W+SET_W:0] t;
        t = IDX_W'(s) * IDX_W'(WAYS) + IDX_W'(w);
        return t[IDX_W-1:0];
    endfunction

    assign rd_way = r_cnt[WAY_W-1:0];
    assign rd_en  = (r_state == S_SCAN || r_state == S_SCAN2) && (r_cnt < (WAY_W+1)'(WAYS));
    assign rd_idx = (r_state == S_VIC) ? idx(set, r_skip) : idx(set, rd_way);

    always_ff @(posedge i_clk) begin
        r_rd_tag   <= m_tag[rd_idx];
        r_rd_stamp <= m_stamp[rd_idx];
        r_rd_flag  <= m_flag[rd_idx];
        r_rd_way   <= rd_way;
    end

    assign view.valid = r_rd_flag[2];
    assign view.hit   = r_rd_flag[2] && (r_rd_tag == tag);
    assign view.stamp = r_rd_stamp;
    assign sc_clear   = (r_state == S_IDLE) || (r_state == S_VIC && !r_pass2);

    savs_scan #(.WAY_W(WAY_W)) u_scan (
        .i_clk     (i_clk),
        .i_clear   (sc_clear),
        .i_step    (r_rd_ok),
        .i_way     (r_rd_way),
        .i_skip_en (r_pass2),
        .i_skip    (r_skip),
        .i_view    (view),
        .o_hit     (sc_hit),
        .o_hit_way (sc_hit_way),
        .o_inv     (sc_inv),
        .o_inv_way (sc_inv_way),
        .o_min_way (sc_min_way)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_REPL[0]: prdata[0] = r_repl;
            default:     prdata[0] = r_wbm;
        endcase
    end

    logic [IDX_W-1:0] wr_idx;
    logic [WAY_W-1:0] wr_way;
    logic             do_fill, do_mark, go_scan2;
    // oldest way not done: scan again without it
    assign go_scan2 = (r_state == S_DONE) && r_req.mode == MODE_FILL && !sc_hit && !sc_inv
                      && !r_pass2 && !r_rd_flag[0];
    assign wr_way  = sc_inv ? sc_inv_way : r_skip;
    assign wr_idx  = idx(set, do_fill ? wr_way : sc_hit_way);
    assign do_fill = (r_state == S_DONE) && r_req.mode == MODE_FILL && !sc_hit && !go_scan2;
    assign do_mark = (r_state == S_DONE) && r_req.mode != MODE_FILL && sc_hit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_flag[r_clr_idx] <= '0;
        end else if (do_fill) begin
            m_tag[wr_idx]   <= tag;
            m_stamp[wr_idx] <= r_req.cycle_stamp;
            m_flag[wr_idx]  <= 3'b100;
        end else if (do_mark) begin
            unique case (r_req.mode)
                MODE_TOUCH: if (r_repl) m_stamp[wr_idx] <= r_req.cycle_stamp;
                MODE_DIRTY: m_flag[wr_idx][1] <= 1'b1;
                default:    m_flag[wr_idx][0] <= 1'b1;
            endcase
        end
    end

    logic [ADDR_WIDTH-1:0] vaddr;
    assign vaddr = (ADDR_WIDTH'(r_rd_tag) << (OFF_W + SBITS)) | (ADDR_WIDTH'(set) << OFF_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_cnt     <= '0;
            r_rd_ok   <= 1'b0;
            r_pass2   <= 1'b0;
            r_repl    <= 1'b1;
            r_wbm     <= 1'b1;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_REPL[0]) r_repl <= pwdata[0];
                else                         r_wbm  <= pwdata[0];
            end
            r_rd_ok <= rd_en;
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(LINES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_pass2 <= 1'b0;
                    r_cnt   <= '0;
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_SCAN2: begin
                    if (rd_en) r_cnt <= r_cnt + 1'b1;
                    else if (!r_rd_ok) begin
                        if (r_state == S_SCAN2
                                || (r_req.mode == MODE_FILL && !sc_hit && !sc_inv)) begin
                            r_skip  <= sc_min_way;
                            r_state <= S_VIC;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                // read flags and tag of the candidate victim
                S_VIC: r_state <= S_DONE;
                S_DONE: begin
                    if (go_scan2) begin
                        r_cnt   <= '0;
                        r_pass2 <= 1'b1;
                        r_state <= S_SCAN2;
                    end else begin
                        r_state <= S_OUT;
                        r_rsp.writeback_needed   <= 1'b0;
                        r_rsp.victim_block_address <= '0;
                        if (r_req.mode == MODE_FILL) begin
                            if (sc_hit) begin
                                r_rsp.status <= ST_FILLHIT;
                                r_rsp.way    <= 3'(sc_hit_way);
                            end else if (sc_inv) begin
                                r_rsp.status <= ST_FILLED;
                                r_rsp.way    <= 3'(sc_inv_way);
                            end else begin
                                r_rsp.status <= ST_OK;
                                r_rsp.way    <= 3'(r_skip);
                                r_rsp.writeback_needed <= r_wbm && r_rd_flag[1];
                                r_rsp.victim_block_address <= 32'(vaddr);
                            end
                        end else if (sc_hit) begin
                            r_rsp.status <= ST_OK;
                            r_rsp.way    <= 3'(sc_hit_way);
                        end else begin
                            r_rsp.status <= ST_MISS;
                            r_rsp.way    <= '0;
                        end
                    end
                end
                S_OUT: if (i_rsp_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign o_rsp       = r_rsp;
endmodule

FILE: rtl/savs_checker.sv
module savs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_req_ready,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input savs_pkg::t_rsp  o_rsp
);
    import savs_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !o_req_ready) else $error("ready while result pending");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped");
    a_miss_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == ST_MISS |-> o_rsp.way == 3'd0)
        else $error("miss with way");
    a_wb_only_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.writeback_needed |-> o_rsp.status == ST_OK)
        else $error("writeback without eviction");
endmodule

bind set_assoc_victim_select_unit savs_checker u_savs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
